/* rtl/lphs_pkg.sv */
// Shared types, constants and the home-slot hash of the linear probing hash set.
`timescale 1ns / 1ps

package lphs_pkg;

    // Table geometry. CAPACITY must be a power of two.
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int KEY_W    = 32;

    localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

    // Operation codes of an input item.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic    present;
        t_status status;
    } t_out_item;

    // Only the low IDX_W bits of key * HASH_MULT matter, and those depend only
    // on the low IDX_W bits of each factor.
    function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] key);
        logic [2*IDX_W-1:0] prod;
        prod = key[IDX_W-1:0] * HASH_MULT[IDX_W-1:0];
        return prod[IDX_W-1:0];
    endfunction

endpackage

/* rtl/lphs_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module lphs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/linear_probe_hash_set.sv */
// Top level of the linear probing hash set: probe sequencer, slot RAM and result register.
`timescale 1ns / 1ps

// The block keeps a set of nonzero 32-bit keys in a table of CAPACITY slots
// held in one synchronous RAM. Each item is an insert, a lookup or a clear,
// and each item gives exactly one result item with a present flag and a
// status. A key's home slot is the low bits of key * 2654435761, and a probe
// walks forward one slot per cycle, wrapping at the end, until it meets the
// key or an empty slot, or has read every slot. Items are handled one at a
// time: an insert or lookup reads one slot per cycle on the single read port
// until its probe ends, about one or two slots on average at no more than
// half load. A clear, an item with a zero key and an unused opcode read no
// slot and go straight to the result. Clearing is done at once through a
// flip-flop valid bit per slot, so no sweep of the RAM is needed after reset
// or after a clear. A finished result sits in an output register, so the
// block takes the next item while that result waits to be taken. Inserts of
// an absent key are refused with a full status once half the slots are in use.
module linear_probe_hash_set (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lphs_pkg::t_in_item  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lphs_pkg::t_out_item o_out_item
);

    import lphs_pkg::*;

    localparam logic [CNT_W-1:0] HALF_CAP  = CNT_W'(CAPACITY / 2);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);

    // Control state.
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_vld [CAPACITY];
    logic             r_slot_vld;
    logic             r_out_valid;

    // Payload of the item in progress.
    logic [1:0]       r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_steps, n_steps;
    t_out_item        r_res, n_res;
    t_out_item        r_out;

    // RAM controls.
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic             ram_we;
    logic [KEY_W-1:0] ram_rdata;
    logic             clr_all;

    logic             start_probe;
    logic             slot_empty;
    logic             slot_hit;
    logic             probe_end;
    logic             out_free;

    lphs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_key),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A slot that was never written since the last clear reads as empty,
    // whatever the RAM holds there.
    assign slot_empty  = !r_slot_vld;
    assign slot_hit    = r_slot_vld && (ram_rdata == r_key);
    assign probe_end   = slot_empty || slot_hit || (r_steps == LAST_STEP);
    assign start_probe = ((i_in_item.opcode == OP_INSERT) || (i_in_item.opcode == OP_LOOKUP))
                         && (i_in_item.key != '0);
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = start_probe ? S_PROBE : S_FINISH;
                end
            end
            S_PROBE: begin
                if (probe_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb begin
        n_op       = r_op;
        n_key      = r_key;
        n_idx      = r_idx;
        n_steps    = r_steps;
        n_res      = r_res;
        n_count    = r_count;
        ram_re     = 1'b0;
        ram_raddr  = r_idx + IDX_W'(1);
        ram_we     = 1'b0;
        clr_all    = 1'b0;
        o_in_ready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_item.opcode;
                    n_key   = i_in_item.key;
                    n_steps = '0;
                    n_res   = '{present: 1'b0, status: ST_DONE};
                    unique case (i_in_item.opcode) inside
                        OP_INSERT, OP_LOOKUP: begin
                            if (i_in_item.key == '0) begin
                                n_res.status = ST_ZERO;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = home_slot(i_in_item.key);
                                n_idx     = home_slot(i_in_item.key);
                            end
                        end
                        OP_CLEAR: begin
                            clr_all = 1'b1;
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_PROBE: begin
                if (slot_hit) begin
                    n_res.present = 1'b1;
                end else if (slot_empty) begin
                    if (r_op == OP_INSERT) begin
                        if (r_count >= HALF_CAP) begin
                            n_res.status = ST_FULL;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end else if (r_steps == LAST_STEP) begin
                    if (r_op == OP_INSERT) begin
                        n_res.status = ST_FULL;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_idx   = r_idx + IDX_W'(1);
                    n_steps = r_steps + IDX_W'(1);
                end
            end
            S_FINISH: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // One valid bit per slot; reset and clear empty the whole table at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (ram_we) begin
            r_vld[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_key   <= n_key;
        r_idx   <= n_idx;
        r_steps <= n_steps;
        r_res   <= n_res;
        if (ram_re) begin
            r_slot_vld <= r_vld[ram_raddr];
        end
        if ((r_state == S_FINISH) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* rtl/lphs_checker.sv */
// Port-level assertions for the linear probing hash set, bound to its top level.
`timescale 1ns / 1ps

module lphs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input lphs_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lphs_pkg::t_out_item o_out_item
);

    import lphs_pkg::*;

    // A waiting result item stays and keeps its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result item dropped or changed while stalled");

    // Items are handled one at a time: acceptance closes the input side.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is in progress");

    // A key found in the table always completes with a done status.
    a_present_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.present) |-> (o_out_item.status == ST_DONE))
        else $error("present result with a status other than done");

    // An input item cannot produce its result in the very next cycle.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared one cycle after acceptance");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (.*);

/* test/tb.sv */
// Self-checking testbench of the linear probing hash set with a tracking model of the key table.
`timescale 1ns / 1ps

module tb;

    import lphs_pkg::*;

    // Opcode 3 has no operation behind it; the block must answer it as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles without any handshake on either channel before the run is declared hung.
    // The longest quiet stretch is the receiver hold-off below plus a long probe.
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 480;
    localparam int QUIET_AFTER   = 480;  // item count after which nobody idles
    localparam int PRESS_AFTER   = 120;  // item count at which the receiver holds off
    localparam int PRESS_CYCLES  = 400;
    localparam int DRAIN_CYCLES  = 20;

    // The tracker mirrors the key table, works out the answer to every
    // accepted item, and checks the block's answers against them in order.
    class key_set_tracker;
        logic [KEY_W-1:0] slots [CAPACITY];
        int unsigned      stored;
        t_out_item        owed_answers [$];
        int unsigned      mismatches;

        function new();
            clear_table();
            mismatches = 0;
        endfunction

        function void clear_table();
            foreach (slots[i]) slots[i] = '0;
            stored = 0;
        endfunction

        function void note_request(t_in_item req);
            t_out_item        ans;
            logic [KEY_W-1:0] prod;
            logic [IDX_W-1:0] idx;
            bit               found;
            bit               hit_empty;
            ans.present = 1'b0;
            ans.status  = ST_DONE;
            if (req.opcode == OP_CLEAR) begin
                clear_table();
            end else if (req.opcode == OP_INSERT || req.opcode == OP_LOOKUP) begin
                if (req.key == '0) begin
                    ans.status = ST_ZERO;
                end else begin
                    prod      = req.key * HASH_MULT;
                    idx       = prod[IDX_W-1:0];
                    found     = 1'b0;
                    hit_empty = 1'b0;
                    // Walk forward from the home slot; the index wraps by its width.
                    for (int n = 0; n < CAPACITY && !found && !hit_empty; n++) begin
                        if (slots[idx] == '0) begin
                            hit_empty = 1'b1;
                        end else if (slots[idx] == req.key) begin
                            found = 1'b1;
                        end else begin
                            idx = idx + IDX_W'(1);
                        end
                    end
                    if (found) begin
                        ans.present = 1'b1;
                    end else if (req.opcode == OP_INSERT) begin
                        if (2 * stored >= CAPACITY || !hit_empty) begin
                            ans.status = ST_FULL;
                        end else begin
                            slots[idx] = req.key;
                            stored++;
                        end
                    end
                end
            end
            owed_answers.push_back(ans);
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (owed_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with none owed: present=%0d status=%0d",
                             $realtime, got.present, got.status);
                end
                return;
            end
            want = owed_answers.pop_front();
            if (got.present !== want.present || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: expected present=%0d status=%0d, got present=%0d status=%0d",
                             $realtime, want.present, want.status, got.present, got.status);
                end
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    key_set_tracker   set_model = new();
    int unsigned      items_taken = 0;
    int unsigned      idle_cycles = 0;
    bit               hold_off_done = 1'b0;

    // Keys handed out in the random part, so that later items can hit them again.
    logic [KEY_W-1:0] key_pool [$];
    int unsigned      cluster_base;

    linear_probe_hash_set dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // A random key whose home slot is the one asked for. Only the low bits of
    // the key decide the home slot, so the search runs over those alone.
    function automatic logic [KEY_W-1:0] key_for_slot(input int unsigned slot);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] prod;
        k = $urandom;
        for (int v = 0; v < CAPACITY; v++) begin
            k[IDX_W-1:0] = v[IDX_W-1:0];
            prod = k * HASH_MULT;
            if (prod[IDX_W-1:0] == slot[IDX_W-1:0]) return k;
        end
        return k;
    endfunction

    // Either a new random key (half of them packed into a narrow run of
    // home slots so that probe chains grow long and wrap), or one from the pool.
    function automatic logic [KEY_W-1:0] pick_key(input int unsigned fresh_pct);
        logic [KEY_W-1:0] k;
        if (key_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
            if ($urandom_range(0, 1) == 0) begin
                k = key_for_slot((cluster_base + $urandom_range(0, 23)) % CAPACITY);
            end else begin
                k = $urandom;
            end
            key_pool.push_back(k);
        end else begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        return k;
    endfunction

    // Offers one item and returns at the falling edge after it is taken. The
    // caller is always at a falling edge. A gap, when one is drawn, lowers
    // valid first; otherwise valid stays high straight into the next item.
    task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key);
        t_in_item req;
        req.opcode = op;
        req.key    = key;
        if (items_taken < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in_item  <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        set_model.note_request(req);
        items_taken++;
        @(negedge i_clk);
    endtask

    // Result side: every taken result goes to the tracker at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            set_model.check_reply(o_out_item);
        end
    end

    // Receiver readiness. Mostly short random stalls, once a long hold-off so
    // that a result sits in the output register and the block stops taking
    // items, and no stalls at all near the end of the run.
    initial begin
        int unsigned hold;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_off_done && items_taken >= PRESS_AFTER) begin
                i_out_ready   <= 1'b0;
                hold          = PRESS_CYCLES;
                hold_off_done = 1'b1;
            end else if (items_taken < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                hold        = $urandom_range(1, 12);
            end else begin
                i_out_ready <= 1'b1;
                hold        = $urandom_range(1, 20);
            end
            repeat (hold) @(negedge i_clk);
        end
    end

    // Watchdog: the run is hung if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int unsigned episode;
        int unsigned span;
        int unsigned insert_pct;
        int unsigned fresh_pct;
        int unsigned pick;
        int unsigned first_random;
        logic [KEY_W-1:0] wrap_keys [3];

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Zero keys on both key operations, the unused opcode,
        // the all-ones key, a repeated insert, and clears with any key.
        send_item(OP_LOOKUP, '0);
        send_item(OP_INSERT, '0);
        send_item(OP_LOOKUP, '1);
        send_item(OP_INSERT, '1);
        send_item(OP_INSERT, '1);
        send_item(OP_LOOKUP, '1);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_UNUSED, '1);
        send_item(OP_UNUSED, '0);

        // Three keys sharing the second to last home slot: the third one wraps
        // around past the end of the table. Then an absent key walks through the wrap.
        foreach (wrap_keys[i]) begin
            wrap_keys[i] = key_for_slot(CAPACITY - 2);
            send_item(OP_INSERT, wrap_keys[i]);
        end
        send_item(OP_LOOKUP, wrap_keys[2]);
        send_item(OP_INSERT, wrap_keys[2]);
        send_item(OP_LOOKUP, key_for_slot(CAPACITY - 1));

        send_item(OP_CLEAR, '1);
        send_item(OP_LOOKUP, '1);
        send_item(OP_LOOKUP, wrap_keys[0]);
        send_item(OP_CLEAR, '0);
        send_item(OP_LOOKUP, 32'h8000_0000);

        // Random part in episodes, each starting from an empty table. The first
        // episode inserts hard enough to reach half load, so refused inserts and
        // repeated inserts into a half-full table show up; its key cluster sits
        // at the top of the table so probe chains wrap around.
        first_random = items_taken;
        episode      = 0;
        while (items_taken < first_random + RANDOM_ITEMS) begin
            key_pool.delete();
            if (episode == 0) begin
                span         = 240;
                insert_pct   = 80;
                fresh_pct    = 90;
                cluster_base = CAPACITY - 16;
            end else begin
                span         = $urandom_range(40, 150);
                insert_pct   = $urandom_range(30, 70);
                fresh_pct    = $urandom_range(40, 80);
                cluster_base = $urandom_range(0, CAPACITY - 1);
            end
            send_item(OP_CLEAR, $urandom);
            for (int s = 0; s < span && items_taken < first_random + RANDOM_ITEMS; s++) begin
                pick = $urandom_range(0, 99);
                if (pick < insert_pct) begin
                    send_item(OP_INSERT, pick_key(fresh_pct));
                end else if (pick < 95) begin
                    send_item(OP_LOOKUP, pick_key(100 - fresh_pct));
                end else if (pick < 97) begin
                    send_item($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, '0);
                end else if (pick < 99) begin
                    send_item(OP_UNUSED, $urandom);
                end else begin
                    send_item(OP_CLEAR, $urandom);
                end
            end
            episode++;
        end

        // All items are in: wait for every owed answer, then a little longer in
        // case the block produces something nobody asked for.
        i_in_valid <= 1'b0;
        while (set_model.owed_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (set_model.mismatches == 0 && set_model.owed_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/lphs_pkg.sv
rtl/lphs_ram.sv
rtl/linear_probe_hash_set.sv
rtl/lphs_checker.sv
test/tb.sv
